// ===== hw/rtl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg: shared widths and types for the sphere collision pipeline
// Field widths, internal arithmetic widths and the geometry record that
// travels down the pipeline with each item.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int COORD_W      = 32;
  localparam int RADIUS_W     = 31;
  localparam int SCALE_W      = 16;
  localparam int SCALE_FRAC   = 8;
  localparam int NORMAL_W     = 16;
  localparam int NORMAL_FRAC  = 14;
  localparam int QUOT_W       = NORMAL_FRAC + 1;
  localparam int PEN_W        = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = RADIUS_W + SCALE_W;
  localparam int SQ_W         = 2 * DIFF_W;
  localparam int SUM_W        = SQ_W + 2;
  localparam int DIST2_W      = 64;
  localparam int SQRT_STEPS   = DIST2_W / 2;
  localparam int DIST_W       = SQRT_STEPS + 1;
  localparam int REM_W        = DIFF_W + NORMAL_FRAC + 1;
  localparam int T2_W         = DIST_W + 2;
  localparam int P_W          = NORMAL_W + T2_W;
  localparam int OFF_W        = P_W - (NORMAL_FRAC + 1);
  localparam int CSUM_W       = OFF_W + 1;
  localparam int DEF_COORD_FRAC_BITS = 16;

  localparam logic [QUOT_W-1:0] NORMAL_ONE = QUOT_W'(1) << NORMAL_FRAC;

  // Geometry carried with each item; index 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] ca;
    logic [2:0][DIFF_W-1:0]  dmag;
    logic [2:0]              dneg;
    logic [RADIUS_W-1:0]     ra;
    logic [RADIUS_W-1:0]     rb;
    logic                    hit;
  } ssc_geo_t;

endpackage

// ===== hw/rtl/ssc_in_if.sv =====
// ----------------------------------------------------------------------------
// ssc_in_if: sphere pair channel
// Valid/ready channel that carries one pair of spheres per item.
// ----------------------------------------------------------------------------
interface ssc_in_if;
  import ssc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  center_a_x;
  logic signed [COORD_W-1:0]  center_a_y;
  logic signed [COORD_W-1:0]  center_a_z;
  logic [RADIUS_W-1:0]        radius_a;
  logic [SCALE_W-1:0]         scale_a;
  logic signed [COORD_W-1:0]  center_b_x;
  logic signed [COORD_W-1:0]  center_b_y;
  logic signed [COORD_W-1:0]  center_b_z;
  logic [RADIUS_W-1:0]        radius_b;
  logic [SCALE_W-1:0]         scale_b;

  modport source (
    output valid, center_a_x, center_a_y, center_a_z, radius_a, scale_a,
           center_b_x, center_b_y, center_b_z, radius_b, scale_b,
    input  ready
  );
  modport sink (
    input  valid, center_a_x, center_a_y, center_a_z, radius_a, scale_a,
           center_b_x, center_b_y, center_b_z, radius_b, scale_b,
    output ready
  );
endinterface

// ===== hw/rtl/ssc_out_if.sv =====
// ----------------------------------------------------------------------------
// ssc_out_if: collision result channel
// Valid/ready channel that carries one contact result per item.
// ----------------------------------------------------------------------------
interface ssc_out_if;
  import ssc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic signed [NORMAL_W-1:0] normal_x;
  logic signed [NORMAL_W-1:0] normal_y;
  logic signed [NORMAL_W-1:0] normal_z;
  logic [PEN_W-1:0]           penetration;
  logic signed [COORD_W-1:0]  contact_x;
  logic signed [COORD_W-1:0]  contact_y;
  logic signed [COORD_W-1:0]  contact_z;

  modport source (
    output valid, hit, normal_x, normal_y, normal_z, penetration,
           contact_x, contact_y, contact_z,
    input  ready
  );
  modport sink (
    input  valid, hit, normal_x, normal_y, normal_z, penetration,
           contact_x, contact_y, contact_z,
    output ready
  );
endinterface

// ===== hw/rtl/ssc_front.sv =====
// ----------------------------------------------------------------------------
// ssc_front: distance and radius front end
// Five stages: center deltas and radius products, magnitudes and radius
// saturation, squares and radius sum, squared sums, and the hit compare.
// ----------------------------------------------------------------------------
module ssc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  ssc_in_if.sink                        pairs,
  output logic                          valid,
  output ssc_pkg::ssc_geo_t             geo,
  output logic [ssc_pkg::DIST2_W-1:0]   dist2
);
  import ssc_pkg::*;

  function automatic logic [RADIUS_W-1:0] sat_radius(input logic [PROD_W-1:0] p);
    if (|p[PROD_W-1:RADIUS_W+SCALE_FRAC]) begin
      return '1;
    end
    return p[RADIUS_W+SCALE_FRAC-1:SCALE_FRAC];
  endfunction

  logic [2:0][COORD_W-1:0] a_in;
  logic [2:0][COORD_W-1:0] b_in;

  logic                    v1, v2, v3, v4;
  logic [2:0][COORD_W-1:0] ca1;
  logic [2:0][DIFF_W-1:0]  d1;
  logic [PROD_W-1:0]       pa1, pb1;
  ssc_geo_t                g2, g3, g4;
  logic [2:0][SQ_W-1:0]    sq3;
  logic [RADIUS_W:0]       rs3;
  logic [DIST2_W-1:0]      rs2_4;
  logic [SUM_W-1:0]        d2_4;
  logic                    hit4;

  assign a_in = {pairs.center_a_z, pairs.center_a_y, pairs.center_a_x};
  assign b_in = {pairs.center_b_z, pairs.center_b_y, pairs.center_b_x};
  assign pairs.ready = en;
  assign hit4 = d2_4 <= {(SUM_W-DIST2_W)'(0), rs2_4};

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, valid} <= '0;
    end else if (en) begin
      v1    <= pairs.valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ca1[k] <= a_in[k];
        d1[k]  <= {b_in[k][COORD_W-1], b_in[k]} - {a_in[k][COORD_W-1], a_in[k]};
      end
      pa1 <= pairs.radius_a * pairs.scale_a;
      pb1 <= pairs.radius_b * pairs.scale_b;

      g2.ca  <= ca1;
      g2.hit <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        g2.dneg[k] <= d1[k][DIFF_W-1];
        g2.dmag[k] <= d1[k][DIFF_W-1] ? (~d1[k] + 1'b1) : d1[k];
      end
      g2.ra <= sat_radius(pa1);
      g2.rb <= sat_radius(pb1);

      g3  <= g2;
      rs3 <= {1'b0, g2.ra} + {1'b0, g2.rb};
      for (int k = 0; k < 3; k++) begin
        sq3[k] <= g2.dmag[k] * g2.dmag[k];
      end

      g4    <= g3;
      rs2_4 <= rs3 * rs3;
      d2_4  <= {2'b0, sq3[0]} + {2'b0, sq3[1]} + {2'b0, sq3[2]};

      geo   <= '{ca: g4.ca, dmag: g4.dmag, dneg: g4.dneg, ra: g4.ra, rb: g4.rb,
                 hit: hit4};
      dist2 <= hit4 ? d2_4[DIST2_W-1:0] : '0;
    end
  end

endmodule

// ===== hw/rtl/ssc_sqrt.sv =====
// ----------------------------------------------------------------------------
// ssc_sqrt: pipelined integer square root
// One result bit per stage, then a rounding stage that gives the distance
// rounded to nearest.
// ----------------------------------------------------------------------------
module ssc_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  ssc_pkg::ssc_geo_t           in_geo,
  input  logic [ssc_pkg::DIST2_W-1:0] in_dist2,
  output logic                        out_valid,
  output ssc_pkg::ssc_geo_t           out_geo,
  output logic [ssc_pkg::DIST_W-1:0]  distance
);
  import ssc_pkg::*;

  logic               vq [1:SQRT_STEPS];
  ssc_geo_t           gq [1:SQRT_STEPS];
  logic [DIST2_W-1:0] xq [1:SQRT_STEPS];
  logic [DIST2_W-1:0] rq [1:SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [DIST2_W-1:0] Bit = DIST2_W'(1) << (DIST2_W - 2 - 2 * j);
    logic               v_cur;
    ssc_geo_t           g_cur;
    logic [DIST2_W-1:0] x_cur, r_cur, trial;
    logic               take;

    if (j == 0) begin : g_first
      assign v_cur = in_valid;
      assign g_cur = in_geo;
      assign x_cur = in_dist2;
      assign r_cur = '0;
    end else begin : g_rest
      assign v_cur = vq[j];
      assign g_cur = gq[j];
      assign x_cur = xq[j];
      assign r_cur = rq[j];
    end

    assign trial = r_cur + Bit;
    assign take  = x_cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[j+1] <= 1'b0;
      end else if (en) begin
        vq[j+1] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        gq[j+1] <= g_cur;
        xq[j+1] <= take ? x_cur - trial : x_cur;
        rq[j+1] <= take ? (r_cur >> 1) + Bit : r_cur >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq[SQRT_STEPS];
    end
  end

  // The remainder is dist2 - root^2; above the root means round up.
  always_ff @(posedge clk) begin
    if (en) begin
      out_geo  <= gq[SQRT_STEPS];
      distance <= DIST_W'(rq[SQRT_STEPS]) +
                  DIST_W'(xq[SQRT_STEPS] > rq[SQRT_STEPS]);
    end
  end

endmodule

// ===== hw/rtl/ssc_div.sv =====
// ----------------------------------------------------------------------------
// ssc_div: normal divider
// Three restoring dividers in lockstep, one quotient bit per stage, giving
// each normal component as |d| * 2^14 / distance rounded to nearest.
// ----------------------------------------------------------------------------
module ssc_div #(
  parameter int COORD_FRAC_BITS = ssc_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  ssc_pkg::ssc_geo_t                    in_geo,
  input  logic [ssc_pkg::DIST_W-1:0]           in_dist,
  output logic                                 out_valid,
  output ssc_pkg::ssc_geo_t                    out_geo,
  output logic [ssc_pkg::DIST_W-1:0]           out_dist,
  output logic                                 out_small,
  output logic [2:0][ssc_pkg::QUOT_W-1:0]      out_quot
);
  import ssc_pkg::*;

  localparam logic [DIST_W-1:0] NORMAL_EPS =
    DIST_W'(((64'd1 << COORD_FRAC_BITS) + 64'd500000) / 64'd1000000);

  logic                   pv;
  ssc_geo_t               pg;
  logic [DIST_W-1:0]      pdist;
  logic                   psmall;
  logic [2:0][REM_W-1:0]  prem;

  logic                   vq   [1:QUOT_W];
  ssc_geo_t               gq   [1:QUOT_W];
  logic [DIST_W-1:0]      dq   [1:QUOT_W];
  logic                   sq   [1:QUOT_W];
  logic [2:0][REM_W-1:0]  remq [1:QUOT_W];
  logic [2:0][QUOT_W-1:0] qq   [1:QUOT_W];

  // Rounding is folded in by adding half the divisor to the dividend.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pg     <= in_geo;
      pdist  <= in_dist;
      psmall <= in_dist <= NORMAL_EPS;
      for (int k = 0; k < 3; k++) begin
        prem[k] <= {1'b0, in_geo.dmag[k], NORMAL_FRAC'(0)} + REM_W'(in_dist >> 1);
      end
    end
  end

  for (genvar j = 0; j < QUOT_W; j++) begin : g_step
    localparam int Shift = QUOT_W - 1 - j;
    logic                   v_cur;
    ssc_geo_t               g_cur;
    logic [DIST_W-1:0]      d_cur;
    logic                   s_cur;
    logic [2:0][REM_W-1:0]  r_cur;
    logic [2:0][QUOT_W-1:0] q_cur;
    logic [REM_W-1:0]       dsh;

    if (j == 0) begin : g_first
      assign v_cur = pv;
      assign g_cur = pg;
      assign d_cur = pdist;
      assign s_cur = psmall;
      assign r_cur = prem;
      assign q_cur = '0;
    end else begin : g_rest
      assign v_cur = vq[j];
      assign g_cur = gq[j];
      assign d_cur = dq[j];
      assign s_cur = sq[j];
      assign r_cur = remq[j];
      assign q_cur = qq[j];
    end

    assign dsh = REM_W'(d_cur) << Shift;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[j+1] <= 1'b0;
      end else if (en) begin
        vq[j+1] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        gq[j+1] <= g_cur;
        dq[j+1] <= d_cur;
        sq[j+1] <= s_cur;
        for (int k = 0; k < 3; k++) begin
          if (r_cur[k] >= dsh) begin
            remq[j+1][k] <= r_cur[k] - dsh;
            qq[j+1][k]   <= q_cur[k] | (QUOT_W'(1) << Shift);
          end else begin
            remq[j+1][k] <= r_cur[k];
            qq[j+1][k]   <= q_cur[k];
          end
        end
      end
    end
  end

  assign out_valid = vq[QUOT_W];
  assign out_geo   = gq[QUOT_W];
  assign out_dist  = dq[QUOT_W];
  assign out_small = sq[QUOT_W];
  assign out_quot  = qq[QUOT_W];

endmodule

// ===== hw/rtl/ssc_tail.sv =====
// ----------------------------------------------------------------------------
// ssc_tail: normal, penetration and contact point
// Signs the normal, scales it by the contact lever, rounds, adds centre A
// with saturation and holds the result in the output register.
// ----------------------------------------------------------------------------
module ssc_tail (
  input  logic                             clk,
  input  logic                             rst,
  output logic                             en,
  input  logic                             in_valid,
  input  ssc_pkg::ssc_geo_t                in_geo,
  input  logic [ssc_pkg::DIST_W-1:0]       in_dist,
  input  logic                             in_small,
  input  logic [2:0][ssc_pkg::QUOT_W-1:0]  in_quot,
  ssc_out_if.source                        results
);
  import ssc_pkg::*;

  localparam logic [P_W-1:0] HALF = P_W'(1) << NORMAL_FRAC;

  logic                      v1, v2, v3;
  logic                      hit1, hit2, hit3;
  logic [2:0][COORD_W-1:0]   ca1, ca2, ca3;
  logic [PEN_W-1:0]          pen1, pen2, pen3;
  logic signed [NORMAL_W-1:0] n1 [3];
  logic signed [NORMAL_W-1:0] n2 [3];
  logic signed [NORMAL_W-1:0] n3 [3];
  logic signed [T2_W-1:0]    t2;
  logic signed [P_W-1:0]     p2 [3];
  logic signed [OFF_W-1:0]   off3 [3];

  logic                      ovalid;
  logic                      ohit;
  logic [2:0][NORMAL_W-1:0]  onorm;
  logic [PEN_W-1:0]          open;
  logic [2:0][COORD_W-1:0]   ocon;

  assign en = !ovalid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, ovalid} <= '0;
    end else if (en) begin
      v1     <= in_valid;
      v2     <= v1;
      v3     <= v2;
      ovalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    logic [QUOT_W-1:0]       qc;
    logic signed [P_W-1:0]   pr;
    logic [CSUM_W-1:0]       cs;
    if (en) begin
      // Stage 1: signed normal, lever rA - rB + dist and penetration.
      hit1 <= in_geo.hit;
      ca1  <= in_geo.ca;
      pen1 <= in_geo.hit ? PEN_W'({1'b0, in_geo.ra} + {1'b0, in_geo.rb} - in_dist) : '0;
      t2   <= {4'b0, in_geo.ra} - {4'b0, in_geo.rb} + {2'b0, in_dist};
      for (int k = 0; k < 3; k++) begin
        qc = (in_quot[k] > NORMAL_ONE) ? NORMAL_ONE : in_quot[k];
        if (!in_geo.hit) begin
          n1[k] <= '0;
        end else if (in_small) begin
          n1[k] <= (k == 0) ? NORMAL_W'(NORMAL_ONE) : '0;
        end else begin
          n1[k] <= in_geo.dneg[k] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        end
      end

      // Stage 2: product.
      hit2 <= hit1;
      ca2  <= ca1;
      pen2 <= pen1;
      for (int k = 0; k < 3; k++) begin
        n2[k] <= n1[k];
        p2[k] <= n1[k] * t2;
      end

      // Stage 3: divide by 2^15, rounding half away from zero.
      hit3 <= hit2;
      ca3  <= ca2;
      pen3 <= pen2;
      for (int k = 0; k < 3; k++) begin
        n3[k] <= n2[k];
        pr = p2[k] + $signed(p2[k] < 0 ? HALF - 1'b1 : HALF);
        off3[k] <= OFF_W'(pr >>> (NORMAL_FRAC + 1));
      end

      // Stage 4: add centre A and saturate.
      ohit <= hit3;
      open <= pen3;
      for (int k = 0; k < 3; k++) begin
        onorm[k] <= n3[k];
        cs = {{(CSUM_W-COORD_W){ca3[k][COORD_W-1]}}, ca3[k]} +
             {off3[k][OFF_W-1], off3[k]};
        if (!hit3) begin
          ocon[k] <= '0;
        end else if (cs[CSUM_W-1:COORD_W-1] == '0 || cs[CSUM_W-1:COORD_W-1] == '1) begin
          ocon[k] <= cs[COORD_W-1:0];
        end else if (cs[CSUM_W-1]) begin
          ocon[k] <= {1'b1, (COORD_W-1)'(0)};
        end else begin
          ocon[k] <= {1'b0, {(COORD_W-1){1'b1}}};
        end
      end
    end
  end

  assign results.valid       = ovalid;
  assign results.hit         = ohit;
  assign results.normal_x    = onorm[0];
  assign results.normal_y    = onorm[1];
  assign results.normal_z    = onorm[2];
  assign results.penetration = open;
  assign results.contact_x   = ocon[0];
  assign results.contact_y   = ocon[1];
  assign results.contact_z   = ocon[2];

endmodule

// ===== hw/rtl/sphere_sphere_collision.sv =====
// Throughput: one pair per cycle unless stalled; every unit is fully pipelined, and
// the square root (one bit per stage) and the normal dividers (one bit per stage) set depth.
// A stalled output freezes the whole pipeline, so ready follows the output stage.
// Reset (rst, synchronous, active high) clears all valid bits; data is unreset.
// ----------------------------------------------------------------------------
// sphere_sphere_collision: streaming sphere-versus-sphere intersection test
// Takes two scaled spheres per item and returns the hit flag, unit normal,
// penetration depth and contact point.
// ----------------------------------------------------------------------------
module sphere_sphere_collision #(
  parameter int COORD_FRAC_BITS = ssc_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  ssc_in_if.sink    pairs,
  ssc_out_if.source results
);
  import ssc_pkg::*;

  // One enable drives every stage. It is high whenever the output register is
  // empty or being drained, so items march forward together and nothing is
  // dropped or duplicated under backpressure.
  logic en;

  // Front end: center deltas, world radii, squared distance and the hit test.
  // A miss sends a zero into the square root so later stages stay harmless.
  logic               f_valid;
  ssc_geo_t           f_geo;
  logic [DIST2_W-1:0] f_dist2;

  // Square root: 32 single-bit stages, then rounding to nearest.
  logic               s_valid;
  ssc_geo_t           s_geo;
  logic [DIST_W-1:0]  s_dist;

  // Dividers: one prep stage and 15 quotient stages, three lanes wide. The
  // near-coincident check against the epsilon is made here as well.
  logic                   d_valid;
  ssc_geo_t               d_geo;
  logic [DIST_W-1:0]      d_dist;
  logic                   d_small;
  logic [2:0][QUOT_W-1:0] d_quot;

  ssc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .pairs (pairs),
    .valid (f_valid),
    .geo   (f_geo),
    .dist2 (f_dist2)
  );

  ssc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_geo    (f_geo),
    .in_dist2  (f_dist2),
    .out_valid (s_valid),
    .out_geo   (s_geo),
    .distance  (s_dist)
  );

  ssc_div #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .in_geo    (s_geo),
    .in_dist   (s_dist),
    .out_valid (d_valid),
    .out_geo   (d_geo),
    .out_dist  (d_dist),
    .out_small (d_small),
    .out_quot  (d_quot)
  );

  // Tail: normal signing, contact lever product, rounding and saturation.
  // It owns the output register and therefore produces the stage enable.
  ssc_tail u_tail (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .in_geo   (d_geo),
    .in_dist  (d_dist),
    .in_small (d_small),
    .in_quot  (d_quot),
    .results  (results)
  );

endmodule
